@@ rtl/vdma_pkg.sv @@
package vdma_pkg;

   // Input operation codes
   localparam logic [1:0] OP_WRITE = 2'd0;
   localparam logic [1:0] OP_READ  = 2'd1;
   localparam logic [1:0] OP_TICK  = 2'd2;

   // Register indexes
   localparam logic [2:0] REG_SRC_HI = 3'd0;
   localparam logic [2:0] REG_SRC_LO = 3'd1;
   localparam logic [2:0] REG_DST_HI = 3'd2;
   localparam logic [2:0] REG_DST_LO = 3'd3;
   localparam logic [2:0] REG_CTRL   = 3'd4;

   // Classified command codes passed from front to back
   localparam logic [2:0] CMD_NOP     = 3'd0;
   localparam logic [2:0] CMD_WR_ADDR = 3'd1;
   localparam logic [2:0] CMD_WR_CTRL = 3'd2;
   localparam logic [2:0] CMD_READ    = 3'd3;
   localparam logic [2:0] CMD_TICK    = 3'd4;

   localparam logic [7:0]  OPEN_BUS    = 8'hFF;
   localparam logic [15:0] VRAM_BASE   = 16'h8000;
   localparam logic [16:0] VRAM_LIMIT  = 17'h0A000;
   localparam logic [15:0] CHUNK_BYTES = 16'd16;
   localparam logic [11:0] CHUNK_LEN   = 12'd16;

   typedef struct packed {
      logic [2:0] code;
      logic [2:0] reg_index;
      logic [7:0] data;
   } cmd_type;

   typedef struct packed {
      logic        blank_transfer_active;
      logic [11:0] copy_length;
      logic [15:0] copy_dest;
      logic [15:0] copy_source;
      logic        copy_valid;
      logic [7:0]  read_data;
   } result_type;

endpackage

@@ rtl/vdma_front.sv @@
module vdma_front
   import vdma_pkg::*;
(
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [4:0] req_tuser,
   input  logic [7:0] req_tdata,
   input  logic       q_full,
   output logic       q_push,
   output cmd_type    q_cmd
);

   logic [1:0] operation;
   logic [2:0] reg_index;

   assign operation = req_tuser[1:0];
   assign reg_index = req_tuser[4:2];

   // Accept whenever the queue has room
   assign req_tready = !q_full;
   assign q_push     = req_tvalid && !q_full;

   // Classify the incoming transfer
   always_comb begin
      q_cmd.reg_index = reg_index;
      q_cmd.data      = req_tdata;
      case (operation)
         OP_WRITE: begin
            if (reg_index inside {[REG_SRC_HI:REG_DST_LO]}) begin
               q_cmd.code = CMD_WR_ADDR;
            end else if (reg_index == REG_CTRL) begin
               q_cmd.code = CMD_WR_CTRL;
            end else begin
               q_cmd.code = CMD_NOP;
            end
         end
         OP_READ: q_cmd.code = CMD_READ;
         OP_TICK: q_cmd.code = CMD_TICK;
         default: q_cmd.code = CMD_NOP;
      endcase
   end

endmodule

@@ rtl/vdma_queue.sv @@
module vdma_queue
   import vdma_pkg::*;
#(
   parameter int DEPTH = 2
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   output logic    full,
   input  logic    pop,
   output logic    pop_valid,
   output cmd_type pop_cmd
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   cmd_type            entry_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push, do_pop;

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_cmd   = entry_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && pop_valid;

   // Advance pointers with wrap at the depth
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the pushed command
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

@@ rtl/vdma_back.sv @@
module vdma_back
   import vdma_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       colour_mode,
   input  logic       q_valid,
   input  cmd_type    q_cmd,
   output logic       q_pop,
   output logic       out_valid,
   input  logic       out_ready,
   output result_type out_result
);

   logic [7:0]  src_hi_ff, src_hi_in;
   logic [7:0]  src_lo_ff, src_lo_in;
   logic [7:0]  dst_hi_ff, dst_hi_in;
   logic [7:0]  dst_lo_ff, dst_lo_in;
   logic [7:0]  ctrl_ff, ctrl_in;
   logic        armed_ff, armed_in;
   logic [15:0] run_src_ff, run_src_in;
   logic [15:0] run_dst_ff, run_dst_in;
   logic [11:0] bytes_left_ff, bytes_left_in;
   logic        out_valid_ff;
   result_type  result_ff, result_in;

   logic [15:0] form_src;
   logic [15:0] form_dst;
   logic [11:0] gen_len;
   logic [11:0] left_next;
   logic [7:0]  data;

   assign data     = q_cmd.data;
   assign form_src = {src_hi_ff, src_lo_ff[7:4], 4'h0};
   assign form_dst = VRAM_BASE | {3'b000, dst_hi_ff[4:0], dst_lo_ff[7:4], 4'h0};
   assign gen_len  = {({1'b0, data[6:0]} + 8'd1), 4'h0};
   assign left_next = bytes_left_ff - CHUNK_LEN;

   // Take the next command when the output register frees up
   assign q_pop      = q_valid && (!out_valid_ff || out_ready);
   assign out_valid  = out_valid_ff;
   assign out_result = result_ff;

   // Execute one command
   always_comb begin
      src_hi_in     = src_hi_ff;
      src_lo_in     = src_lo_ff;
      dst_hi_in     = dst_hi_ff;
      dst_lo_in     = dst_lo_ff;
      ctrl_in       = ctrl_ff;
      armed_in      = armed_ff;
      run_src_in    = run_src_ff;
      run_dst_in    = run_dst_ff;
      bytes_left_in = bytes_left_ff;
      result_in     = '0;
      case (q_cmd.code)
         CMD_WR_ADDR: begin
            case (q_cmd.reg_index)
               REG_SRC_HI: src_hi_in = data;
               REG_SRC_LO: src_lo_in = data;
               REG_DST_HI: dst_hi_in = data;
               REG_DST_LO: dst_lo_in = data;
               default: ;
            endcase
         end
         CMD_WR_CTRL: begin
            ctrl_in = data;
            if (armed_ff && !data[7]) begin
               // Cancel the armed blank transfer
               armed_in = 1'b0;
               ctrl_in  = data | 8'h80;
            end else if (colour_mode) begin
               if (data[7]) begin
                  // Arm a per-blank transfer; keep running addresses on re-arm
                  ctrl_in = data & 8'h7F;
                  if (!armed_ff) begin
                     run_src_in = form_src;
                     run_dst_in = form_dst;
                  end
                  armed_in      = 1'b1;
                  bytes_left_in = gen_len;
               end else begin
                  // General transfer: one copy for the whole length
                  result_in.copy_valid  = 1'b1;
                  result_in.copy_source = form_src;
                  result_in.copy_dest   = form_dst;
                  result_in.copy_length = gen_len;
                  ctrl_in               = OPEN_BUS;
               end
            end
         end
         CMD_READ: begin
            if (!colour_mode) begin
               result_in.read_data = OPEN_BUS;
            end else begin
               case (q_cmd.reg_index)
                  REG_SRC_HI: result_in.read_data = src_hi_ff;
                  REG_SRC_LO: result_in.read_data = src_lo_ff;
                  REG_DST_HI: result_in.read_data = dst_hi_ff;
                  REG_DST_LO: result_in.read_data = dst_lo_ff;
                  REG_CTRL:   result_in.read_data = ctrl_ff;
                  default:    result_in.read_data = OPEN_BUS;
               endcase
            end
         end
         CMD_TICK: begin
            if (armed_ff) begin
               if (({1'b0, run_dst_ff} + {1'b0, CHUNK_BYTES}) > VRAM_LIMIT) begin
                  // Stop at the end of VRAM
                  armed_in = 1'b0;
                  ctrl_in  = OPEN_BUS;
               end else begin
                  result_in.copy_valid  = 1'b1;
                  result_in.copy_source = run_src_ff;
                  result_in.copy_dest   = run_dst_ff;
                  result_in.copy_length = CHUNK_LEN;
                  run_src_in    = run_src_ff + CHUNK_BYTES;
                  run_dst_in    = run_dst_ff + CHUNK_BYTES;
                  bytes_left_in = left_next;
                  if (left_next == '0) begin
                     armed_in = 1'b0;
                     ctrl_in  = OPEN_BUS;
                  end else begin
                     ctrl_in = {ctrl_ff[7], left_next[10:4] - 7'd1};
                  end
               end
            end
         end
         default: ;
      endcase
      result_in.blank_transfer_active = armed_in;
   end

   // Update architectural state on each executed command
   always_ff @(posedge clock) begin
      if (reset) begin
         src_hi_ff     <= OPEN_BUS;
         src_lo_ff     <= OPEN_BUS;
         dst_hi_ff     <= OPEN_BUS;
         dst_lo_ff     <= OPEN_BUS;
         ctrl_ff       <= OPEN_BUS;
         armed_ff      <= 1'b0;
         run_src_ff    <= '0;
         run_dst_ff    <= '0;
         bytes_left_ff <= '0;
      end else if (q_pop) begin
         src_hi_ff     <= src_hi_in;
         src_lo_ff     <= src_lo_in;
         dst_hi_ff     <= dst_hi_in;
         dst_lo_ff     <= dst_lo_in;
         ctrl_ff       <= ctrl_in;
         armed_ff      <= armed_in;
         run_src_ff    <= run_src_in;
         run_dst_ff    <= run_dst_in;
         bytes_left_ff <= bytes_left_in;
      end
   end

   // Hold the result until the transfer completes
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (q_pop) begin
         out_valid_ff <= 1'b1;
      end else if (out_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         result_ff <= result_in;
      end
   end

endmodule

@@ rtl/vram_dma_controller.sv @@
// VRAM DMA register block for colour mode. Each request is a register write,
// a register read or a horizontal-blank tick, and each yields exactly one
// response carrying read data and, where one is issued, a copy command. A
// front stage classifies requests into a QUEUE_DEPTH-entry command queue; a
// back stage executes one command per cycle against the DMA registers while
// the response is free or taken, and holds the response in an output register.
// Throughput is one request per cycle while responses are taken; a request
// passes the queue register, then the output register, before its response
// is valid. The colour_mode bit is written over the csr channel, always ready.
module vram_dma_controller
   import vdma_pkg::*;
#(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // write_data[7:0]
   input  logic [4:0]  req_tuser,   // operation[1:0], reg_index[4:2]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // read_data[7:0], copy_source[23:8], copy_dest[39:24], copy_length[51:40],
   // blank_transfer_active[52], zero fill [55:53]
   output logic [55:0] rsp_tdata,
   output logic [0:0]  rsp_tuser,   // copy_valid[0]
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_data
);

   logic       colour_mode_ff;
   logic       q_full, q_push, q_pop, q_valid;
   cmd_type    push_cmd, pop_cmd;
   result_type result;

   // Store the colour mode bit
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         colour_mode_ff <= 1'b0;
      end else if (csr_valid) begin
         colour_mode_ff <= csr_data;
      end
   end

   vdma_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_cmd      (push_cmd)
   );

   vdma_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_cmd  (push_cmd),
      .full      (q_full),
      .pop       (q_pop),
      .pop_valid (q_valid),
      .pop_cmd   (pop_cmd)
   );

   vdma_back u_back (
      .clock       (clock),
      .reset       (reset),
      .colour_mode (colour_mode_ff),
      .q_valid     (q_valid),
      .q_cmd       (pop_cmd),
      .q_pop       (q_pop),
      .out_valid   (rsp_tvalid),
      .out_ready   (rsp_tready),
      .out_result  (result)
   );

   // Pack the response
   assign rsp_tdata = {3'b000, result.blank_transfer_active, result.copy_length,
                       result.copy_dest, result.copy_source, result.read_data};
   assign rsp_tuser = result.copy_valid;

`ifndef NO_ASSERTIONS
   // An issued copy always targets VRAM
   a_copy_in_vram: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[0]) |-> (rsp_tdata[39:37] == 3'b100))
      else $error("copy destination outside VRAM");

   // An issued copy never has zero length
   a_copy_len: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[0]) |-> (rsp_tdata[51:40] != 12'd0))
      else $error("copy with zero length");

   // Without a copy the command fields are clear
   a_no_copy_clear: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser[0]) |-> (rsp_tdata[51:8] == 44'd0))
      else $error("copy fields set without a copy");
`endif

endmodule
